@@ hdl/dgram_pkg.sv @@
package dgram_pkg;

    localparam int DATA_W   = 8;
    localparam int INDEX_W  = 10;
    localparam int LENGTH_W = 16;

    localparam int MAX_PAYLOAD_DEFAULT = 1024;

    // fixed frame header, first byte first
    localparam logic [DATA_W-1:0] HDR_BYTES [3] = '{8'h01, 8'h02, 8'h03};

    // framing overhead: header, sequence, two length bytes, checksum
    localparam logic [LENGTH_W:0] FRAME_OVERHEAD = 17'd7;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_HEADER   = 2'd1,
        ST_BAD_CHECKSUM = 2'd2,
        ST_BAD_LENGTH   = 2'd3
    } status_t;

endpackage

@@ hdl/dgram_in_if.sv @@
interface dgram_in_if
    import dgram_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

@@ hdl/dgram_out_if.sv @@
interface dgram_out_if
    import dgram_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic                is_status;
    logic [DATA_W-1:0]   payload_byte;
    logic [INDEX_W-1:0]  payload_index;
    status_t             status_code;
    logic [DATA_W-1:0]   sequence_number;
    logic [LENGTH_W-1:0] payload_length;
    logic                start_request;

    modport source (
        output valid, output is_status, output payload_byte, output payload_index,
        output status_code, output sequence_number, output payload_length,
        output start_request, input ready
    );
    modport sink (
        input valid, input is_status, input payload_byte, input payload_index,
        input status_code, input sequence_number, input payload_length,
        input start_request, output ready
    );
endinterface

@@ hdl/datagram_deframer_checksum_core.sv @@
// datagram deframer with additive 8-bit checksum
//
// data_ch takes one datagram byte per transfer; end_of_datagram marks the
// last byte. a frame is header 01 02 03, a sequence byte, a little-endian
// 16-bit payload length, the payload and a checksum byte (sum mod 256 of
// all earlier bytes).
// result_ch gives one transfer per payload byte (byte and index) while
// header and length are good, and one status transfer on the last byte:
// ok, bad header/checksum/length, with sequence byte, length field and start flag.
// a result appears in the cycle after its byte is taken, from the result
// register. throughput: one byte per cycle while that register is free or
// draining; the parse step is a few compares and one 8-bit add before it.
// stalls: a new byte is taken whenever the result register is empty or is
// being drained in the same cycle, so a stalled receiver holds off input
// only while a result is actually waiting.
// reset: parser returns to the first header byte, sums and captured
// fields clear, the result register empties. every status also returns
// the parser to that state for the next datagram.
module datagram_deframer_checksum_core
    import dgram_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    dgram_in_if.sink         data_ch,
    dgram_out_if.source      result_ch
);

    localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(MAX_PAYLOAD);
    localparam logic [LENGTH_W-1:0] POS_SAT = '1;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_SEQ     = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_LEN_HI  = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_PAST    = 3'd7
    } phase_t;

    // parser state
    phase_t              phase_reg, phase_next;
    logic [LENGTH_W-1:0] pos_reg, pos_next;
    logic [DATA_W-1:0]   sum_reg, sum_next;
    logic                hdr_good_reg, hdr_good_next;
    logic [DATA_W-1:0]   seq_reg, seq_next;
    logic [LENGTH_W-1:0] len_reg, len_next;
    logic                first_one_reg, first_one_next;
    logic                len_bad_reg, len_bad_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic                is_status_reg, is_status_next;
    logic [DATA_W-1:0]   pbyte_reg, pbyte_next;
    logic [INDEX_W-1:0]  pindex_reg, pindex_next;
    status_t             code_reg, code_next;
    logic [DATA_W-1:0]   oseq_reg, oseq_next;
    logic [LENGTH_W-1:0] olen_reg, olen_next;
    logic                start_reg, start_next;

    logic                accept;
    logic [DATA_W-1:0]   b;
    logic [LENGTH_W-1:0] idx;
    logic [LENGTH_W-1:0] pos_plus;
    logic [LENGTH_W-1:0] full_len;
    logic                hdr_ok;
    logic                len_ok;
    status_t             code;

    // accept while the result register is empty or draining
    assign data_ch.ready = !out_valid_reg || result_ch.ready;
    assign accept        = data_ch.valid && data_ch.ready;
    assign b             = data_ch.data_byte;

    // payload index and bytes-consumed-in-payload count
    assign idx      = pos_reg - LENGTH_W'(6);
    assign pos_plus = pos_reg - LENGTH_W'(5);
    assign full_len = {b, len_reg[DATA_W-1:0]};

    // end-of-datagram checks
    assign hdr_ok = hdr_good_reg &&
        (phase_reg >= PH_SEQ || (phase_reg == PH_HDR2 && b == HDR_BYTES[2]));
    assign len_ok = !len_bad_reg && phase_reg >= PH_PAYLOAD && pos_reg != POS_SAT &&
        ({1'b0, pos_reg} + 17'd1) == (FRAME_OVERHEAD + {1'b0, len_reg});

    always_comb
    begin
        if (!hdr_ok) begin
            code = ST_BAD_HEADER;
        end else if (!len_ok) begin
            code = ST_BAD_LENGTH;
        end else if (b != sum_reg) begin
            code = ST_BAD_CHECKSUM;
        end else begin
            code = ST_OK;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        hdr_good_next  = hdr_good_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        first_one_next = first_one_reg;
        len_bad_next   = len_bad_reg;

        out_valid_next = out_valid_reg && !result_ch.ready;
        is_status_next = is_status_reg;
        pbyte_next     = pbyte_reg;
        pindex_next    = pindex_reg;
        code_next      = code_reg;
        oseq_next      = oseq_reg;
        olen_next      = olen_reg;
        start_next     = start_reg;

        if (accept) begin
            if (!data_ch.end_of_datagram) begin
                out_valid_next = 1'b0;
                case (phase_reg)
                    PH_HDR0, PH_HDR1, PH_HDR2:
                    begin
                        if (b != HDR_BYTES[phase_reg[1:0]]) begin
                            hdr_good_next = 1'b0;
                        end
                        phase_next = phase_t'(phase_reg + 3'd1);
                    end
                    PH_SEQ:
                    begin
                        seq_next   = b;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        len_next   = {{(LENGTH_W-DATA_W){1'b0}}, b};
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        len_next = full_len;
                        if (full_len > MAX_LEN) begin
                            len_bad_next = 1'b1;
                        end
                        phase_next = (full_len == '0) ? PH_PAST : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        if (idx == '0 && b == 8'd1) begin
                            first_one_next = 1'b1;
                        end
                        if (hdr_good_reg && !len_bad_reg) begin
                            out_valid_next = 1'b1;
                            is_status_next = 1'b0;
                            pbyte_next     = b;
                            pindex_next    = idx[INDEX_W-1:0];
                            code_next      = ST_OK;
                            oseq_next      = '0;
                            olen_next      = '0;
                            start_next     = 1'b0;
                        end
                        if (pos_plus >= len_reg) begin
                            phase_next = PH_PAST;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                sum_next = sum_reg + b;
                if (pos_reg != POS_SAT) begin
                    pos_next = pos_reg + LENGTH_W'(1);
                end
            end else begin
                // status transfer, then back to the first header byte
                out_valid_next = 1'b1;
                is_status_next = 1'b1;
                pbyte_next     = '0;
                pindex_next    = '0;
                code_next      = code;
                oseq_next      = seq_reg;
                olen_next      = len_reg;
                start_next     = (code == ST_OK) && first_one_reg;

                phase_next     = PH_HDR0;
                pos_next       = '0;
                sum_next       = '0;
                hdr_good_next  = 1'b1;
                seq_next       = '0;
                len_next       = '0;
                first_one_next = 1'b0;
                len_bad_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_HDR0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            hdr_good_reg  <= 1'b1;
            seq_reg       <= '0;
            len_reg       <= '0;
            first_one_reg <= 1'b0;
            len_bad_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            is_status_reg <= 1'b0;
            pbyte_reg     <= '0;
            pindex_reg    <= '0;
            code_reg      <= ST_OK;
            oseq_reg      <= '0;
            olen_reg      <= '0;
            start_reg     <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            hdr_good_reg  <= hdr_good_next;
            seq_reg       <= seq_next;
            len_reg       <= len_next;
            first_one_reg <= first_one_next;
            len_bad_reg   <= len_bad_next;
            out_valid_reg <= out_valid_next;
            is_status_reg <= is_status_next;
            pbyte_reg     <= pbyte_next;
            pindex_reg    <= pindex_next;
            code_reg      <= code_next;
            oseq_reg      <= oseq_next;
            olen_reg      <= olen_next;
            start_reg     <= start_next;
        end
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.is_status       = is_status_reg;
    assign result_ch.payload_byte    = pbyte_reg;
    assign result_ch.payload_index   = pindex_reg;
    assign result_ch.status_code     = code_reg;
    assign result_ch.sequence_number = oseq_reg;
    assign result_ch.payload_length  = olen_reg;
    assign result_ch.start_request   = start_reg;

endmodule

@@ tb/deframer_result_check.sv @@
`timescale 1ns / 1ps

module deframer_result_check
    import dgram_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    dgram_in_if  data_ch,
    dgram_out_if result_ch,
    output int   errors,
    output int   pending,
    output int   payload_seen,
    output int   ok_seen,
    output int   hdr_fail_seen,
    output int   sum_fail_seen,
    output int   len_fail_seen
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_SEQ,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY,
        PH_PAST
    } parse_phase_t;

    typedef struct packed {
        logic                is_status;
        logic [DATA_W-1:0]   pbyte;
        logic [INDEX_W-1:0]  pindex;
        status_t             code;
        logic [DATA_W-1:0]   seq;
        logic [LENGTH_W-1:0] length;
        logic                start;
    } dgram_result_t;

    parse_phase_t        phase;
    logic [15:0]         byte_pos;
    logic [7:0]          run_sum;
    logic                hdr_good;
    logic [DATA_W-1:0]   seq_held;
    logic [LENGTH_W-1:0] len_held;
    logic                first_is_one;
    logic                len_bad;

    dgram_result_t expected_q[$];

    function automatic void clear_frame();
        phase        = PH_HDR0;
        byte_pos     = '0;
        run_sum      = '0;
        hdr_good     = 1'b1;
        seq_held     = '0;
        len_held     = '0;
        first_is_one = 1'b0;
        len_bad      = 1'b0;
    endfunction

    // advance the parser by one byte, queue whatever result it causes
    function automatic void parse_byte(logic [DATA_W-1:0] b, logic last);
        logic [31:0]   idx;
        logic [16:0]   size;
        logic          hdr_ok;
        logic          len_ok;
        dgram_result_t r;
        r = '0;
        if (!last) begin
            case (phase)
                PH_HDR0, PH_HDR1, PH_HDR2: begin
                    if (b != HDR_BYTES[int'(phase)])
                        hdr_good = 1'b0;
                    phase = parse_phase_t'(phase + 3'd1);
                end
                PH_SEQ: begin
                    seq_held = b;
                    phase    = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_held = {8'h00, b};
                    phase    = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_held = {b, len_held[7:0]};
                    if (int'(len_held) > MAX_PAYLOAD)
                        len_bad = 1'b1;
                    phase = (len_held == '0) ? PH_PAST : PH_BODY;
                end
                PH_BODY: begin
                    idx = {16'd0, byte_pos} - 32'd6;
                    if (idx == 0 && b == 8'h01)
                        first_is_one = 1'b1;
                    if (hdr_good && !len_bad) begin
                        r.pbyte  = b;
                        r.pindex = idx[INDEX_W-1:0];
                        expected_q.push_back(r);
                    end
                    if (idx + 32'd1 >= {16'd0, len_held})
                        phase = PH_PAST;
                end
                default: ;
            endcase
            run_sum = run_sum + b;
            if (byte_pos != 16'hFFFF)
                byte_pos = byte_pos + 16'd1;
        end
        else begin
            hdr_ok = hdr_good && (phase >= PH_SEQ || (phase == PH_HDR2 && b == HDR_BYTES[2]));
            size   = {1'b0, byte_pos} + 17'd1;
            len_ok = !len_bad && phase >= PH_BODY && byte_pos != 16'hFFFF &&
                     size == FRAME_OVERHEAD + {1'b0, len_held};
            r.is_status = 1'b1;
            if (!hdr_ok)
                r.code = ST_BAD_HEADER;
            else if (!len_ok)
                r.code = ST_BAD_LENGTH;
            else if (b != run_sum)
                r.code = ST_BAD_CHECKSUM;
            else
                r.code = ST_OK;
            r.seq    = seq_held;
            r.length = len_held;
            r.start  = (r.code == ST_OK) && first_is_one;
            expected_q.push_back(r);
            clear_frame();
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // results are compared before the byte of this edge is parsed
    always @(posedge clk or negedge rst_n) begin : monitor
        dgram_result_t got;
        dgram_result_t want;
        if (!rst_n) begin
            clear_frame();
            expected_q.delete();
        end
        else begin
            if (result_ch.valid && result_ch.ready) begin
                got.is_status = result_ch.is_status;
                got.pbyte     = result_ch.payload_byte;
                got.pindex    = result_ch.payload_index;
                got.code      = result_ch.status_code;
                got.seq       = result_ch.sequence_number;
                got.length    = result_ch.payload_length;
                got.start     = result_ch.start_request;
                if (expected_q.size() == 0) begin
                    errors++;
                    $error("result transfer with nothing expected: %p", got);
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("is_status", want.is_status, got.is_status);
                    check_field("payload_byte", want.pbyte, got.pbyte);
                    check_field("payload_index", want.pindex, got.pindex);
                    check_field("status_code", want.code, got.code);
                    check_field("sequence_number", want.seq, got.seq);
                    check_field("payload_length", want.length, got.length);
                    check_field("start_request", want.start, got.start);
                    if (!want.is_status)
                        payload_seen++;
                    else
                        case (want.code)
                            ST_OK:           ok_seen++;
                            ST_BAD_HEADER:   hdr_fail_seen++;
                            ST_BAD_CHECKSUM: sum_fail_seen++;
                            default:         len_fail_seen++;
                        endcase
                end
            end
            if (data_ch.valid && data_ch.ready)
                parse_byte(data_ch.data_byte, data_ch.end_of_datagram);
        end
        pending = expected_q.size();
    end

endmodule

@@ tb/tb_datagram_deframer_checksum_core.sv @@
`timescale 1ns / 1ps

module tb_datagram_deframer_checksum_core;
    import dgram_pkg::*;

    localparam int LEN_BOUND    = MAX_PAYLOAD_DEFAULT;
    localparam int RANDOM_BYTES = 600;
    // receiver hold-off, long enough to fill the result register and stall input
    localparam int HOLD_CYCLES  = 300;
    // margin after the drain; ample, since results come from a register
    localparam int DRAIN_CYCLES = 10;
    // cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT   = 2000;

    logic clk;
    logic rst_n;

    dgram_in_if  data_ch ();
    dgram_out_if result_ch ();

    int fail_count;
    int pending;
    int payload_seen;
    int ok_seen;
    int hdr_fail_seen;
    int sum_fail_seen;
    int len_fail_seen;

    // bytes of the datagram being built, first byte first
    logic [7:0] dgram[$];

    int dgram_count;
    int byte_count;

    // idling switches for each side, and the request for the long hold-off
    bit src_gaps;
    bit sink_gaps;
    bit hold_req;

    datagram_deframer_checksum_core #(
        .MAX_PAYLOAD (LEN_BOUND)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_ch   (data_ch),
        .result_ch (result_ch)
    );

    deframer_result_check #(
        .MAX_PAYLOAD (LEN_BOUND)
    ) u_result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_ch       (data_ch),
        .result_ch     (result_ch),
        .errors        (fail_count),
        .pending       (pending),
        .payload_seen  (payload_seen),
        .ok_seen       (ok_seen),
        .hdr_fail_seen (hdr_fail_seen),
        .sum_fail_seen (sum_fail_seen),
        .len_fail_seen (len_fail_seen)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // offer one byte, with random idle cycles in front, and wait for its transfer
    // ready is sampled at the falling edge, where it is settled for the coming edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        bit taken;
        taken = 1'b0;
        while (src_gaps && $urandom_range(0, 99) < 16) begin
            data_ch.valid <= 1'b0;
            @(posedge clk);
        end
        data_ch.valid           <= 1'b1;
        data_ch.data_byte       <= b;
        data_ch.end_of_datagram <= last;
        do
        begin
            @(negedge clk);
            taken = data_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        byte_count++;
    endtask

    task automatic send_dgram();
        foreach (dgram[i])
            send_byte(dgram[i], i == dgram.size() - 1);
        dgram_count++;
    endtask

    // header, sequence, length field and body bytes, checksum not yet added
    task automatic make_frame(input logic [7:0] seq, input logic [15:0] len_f,
                              input int body);
        dgram.delete();
        dgram.push_back(HDR_BYTES[0]);
        dgram.push_back(HDR_BYTES[1]);
        dgram.push_back(HDR_BYTES[2]);
        dgram.push_back(seq);
        dgram.push_back(len_f[7:0]);
        dgram.push_back(len_f[15:8]);
        repeat (body)
            dgram.push_back(8'($urandom));
    endtask

    // append the checksum byte, or a wrong one
    task automatic seal(input bit good);
        logic [7:0] sum;
        sum = '0;
        foreach (dgram[i])
            sum = sum + dgram[i];
        dgram.push_back(good ? sum : sum + 8'($urandom_range(1, 255)));
    endtask

    // sample the checker at the falling edge so the count is settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // receiver: random stalls, a stall-free stretch, and one long hold-off
    initial begin : receiver
        int hold_left;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (sink_gaps)
                result_ch.ready <= ($urandom_range(0, 99) >= 16);
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog: ends the run if neither channel makes a transfer for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((data_ch.valid && data_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transfer for %0d cycles, %0d results still expected",
               IDLE_LIMIT, pending);
        $display("FAIL datagram_deframer_checksum_core");
        $finish;
    end

    initial begin : stimulus
        int          kind;
        int          body;
        int          cut;
        int          k;
        int          random_start;
        logic [15:0] len_f;
        logic [7:0]  seq;

        rst_n                   = 1'b0;
        data_ch.valid           = 1'b0;
        data_ch.data_byte       = '0;
        data_ch.end_of_datagram = 1'b0;
        src_gaps                = 1'b1;
        sink_gaps               = 1'b1;
        hold_req                = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed datagrams ----

        // single byte: ends inside the header, header mismatch
        dgram = {8'h00};
        send_dgram();
        // good header that ends on its third byte: length error, fields read as zero
        dgram = {8'h01, 8'h02, 8'h03};
        send_dgram();
        // header broken on the final byte
        dgram = {8'h01, 8'h02, 8'hFF};
        send_dgram();
        // ends on the low length byte, which is never captured
        dgram = {8'h01, 8'h02, 8'h03, 8'h55, 8'hAA};
        send_dgram();
        // ends on the high length byte: only the low byte is reported
        dgram = {8'h01, 8'h02, 8'h03, 8'h55, 8'hAA, 8'hBB};
        send_dgram();
        // empty payload, good checksum: ok without start request
        make_frame(8'h00, 16'd0, 0);
        seal(1'b1);
        send_dgram();
        // first payload byte is one: ok with start request
        make_frame(8'hFF, 16'd3, 3);
        dgram[6] = 8'h01;
        seal(1'b1);
        send_dgram();
        // start byte present but checksum wrong: no start request
        make_frame(8'h80, 16'd2, 2);
        dgram[6] = 8'h01;
        seal(1'b0);
        send_dgram();
        // bad header and bad checksum together: header wins
        make_frame(8'h11, 16'd1, 1);
        dgram[0] = 8'hFE;
        seal(1'b0);
        send_dgram();
        // largest length field: over the bound, payload suppressed
        make_frame(8'h22, 16'hFFFF, 2);
        seal(1'b1);
        send_dgram();
        // size disagrees with the length field though the checksum is right
        make_frame(8'h33, 16'd4, 6);
        seal(1'b1);
        send_dgram();
        // length field exactly at the bound, short body: payload passes, then length error
        make_frame(8'h44, 16'(LEN_BOUND), 3);
        seal(1'b1);
        send_dgram();
        // length field one past the bound: length error, no payload results
        make_frame(8'h66, 16'(LEN_BOUND + 1), 3);
        seal(1'b1);
        send_dgram();

        // sender pauses until every result of the directed part is in
        data_ch.valid <= 1'b0;
        wait_drained();

        // ---- random datagrams ----

        // receiver holds off at the start while the sender keeps offering
        hold_req     = 1'b1;
        random_start = byte_count;
        while (byte_count < random_start + RANDOM_BYTES) begin
            // middle stretch runs with no idling on either side
            src_gaps  = !(byte_count >= random_start + 200 &&
                          byte_count <  random_start + 400);
            sink_gaps = src_gaps;

            seq   = 8'($urandom);
            len_f = 16'($urandom_range(0, ($urandom_range(0, 99) < 4) ? 64 : 12));
            body  = int'(len_f);
            kind  = $urandom_range(0, 99);
            if (kind >= 84 && kind < 90) begin
                // length field over the bound
                len_f = 16'($urandom_range(LEN_BOUND + 1, 65535));
                body  = $urandom_range(0, 6);
            end
            else if (kind >= 76 && kind < 84) begin
                // size off from the length field
                if (len_f == 0 || $urandom_range(0, 1) == 1)
                    body = int'(len_f) + $urandom_range(1, 3);
                else
                    body = int'(len_f) - 1;
            end
            if (kind < 96) begin
                make_frame(seq, len_f, body);
                if (body > 0 && $urandom_range(0, 2) == 0)
                    dgram[6] = 8'h01;
                if (kind >= 68 && kind < 76) begin
                    k        = $urandom_range(0, 2);
                    dgram[k] = dgram[k] ^ (8'h01 << $urandom_range(0, 7));
                end
                seal(!(kind >= 60 && kind < 68));
                if (kind >= 90) begin
                    // cut short somewhere in the header, sequence byte or length field
                    cut   = $urandom_range(1, 6);
                    dgram = dgram[0:cut-1];
                end
            end
            else begin
                // plain noise
                dgram.delete();
                repeat ($urandom_range(1, 20))
                    dgram.push_back(8'($urandom));
            end
            send_dgram();
        end
        data_ch.valid <= 1'b0;

        // ---- wind down ----
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d datagrams in %0d byte transfers, %0d payload results",
                 dgram_count, byte_count, payload_seen);
        $display("status results: ok %0d, bad header %0d, bad checksum %0d, bad length %0d",
                 ok_seen, hdr_fail_seen, sum_fail_seen, len_fail_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS datagram_deframer_checksum_core");
        else begin
            if (pending != 0)
                $error("%0d expected results never arrived", pending);
            $display("FAIL datagram_deframer_checksum_core");
        end
        $finish;
    end

endmodule
